### src/best_fit_coalescing_allocator_macros.svh
// Assertion macros shared by the allocator RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef BEST_FIT_COALESCING_ALLOCATOR_MACROS_SVH
`define BEST_FIT_COALESCING_ALLOCATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### src/bfca_pkg.sv
// Shared types and constants of the best-fit allocator.
// No dependencies.
`default_nettype none
package bfca_pkg;
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [1:0] STATUS_TABLE_FULL = 2'd2;

  localparam logic REG_HEADER_SIZE = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE = 1'b1;

  typedef enum logic [1:0] {OP_HOLD, OP_ROTATE, OP_DROP, OP_PUT} cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     wr_en;
  } cell_ctl_t;
endpackage
`default_nettype wire

### src/bfca_cell.sv
// One slot of the free-chunk table: a start and a payload length.
// Depends on bfca_pkg; shifts to or from its neighbors under a shared control.
`default_nettype none
module bfca_cell
  import bfca_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int CW = 7,
  parameter int AW = 32
) (
  input  wire logic          clk,
  input  wire cell_ctl_t     ctl,
  input  wire logic [CW-1:0] sel_idx,
  input  wire logic [CW-1:0] wr_idx,
  input  wire logic [AW-1:0] wr_start,
  input  wire logic [31:0]   wr_len,
  input  wire logic [AW-1:0] left_start,
  input  wire logic [31:0]   left_len,
  input  wire logic [AW-1:0] right_start,
  input  wire logic [31:0]   right_len,
  output logic [AW-1:0]      start,
  output logic [31:0]        len
);
  always_ff @(posedge clk) begin
    if (ctl.wr_en && wr_idx == CW'(INDEX)) begin
      start <= wr_start;
      len <= wr_len;
    end else begin
      case (ctl.op)
        OP_ROTATE: begin
          start <= right_start;
          len <= right_len;
        end
        OP_DROP: begin
          if (CW'(INDEX) >= sel_idx) begin
            start <= right_start;
            len <= right_len;
          end
        end
        OP_PUT: begin
          if (CW'(INDEX) > sel_idx) begin
            start <= left_start;
            len <= left_len;
          end
        end
        default: begin
        end
      endcase
    end
  end
endmodule
`default_nettype wire

### src/best_fit_coalescing_allocator.sv
// One item at a time: a request is taken only in the idle state, and its result follows the scan and update.
// The table rotates once through the cell chain to be scanned,
// then the arithmetic states S_CALC1, S_CALC2 and S_CALC3 and the update state S_APPLY follow.
// A new item is taken only after the last result is issued; a wait on the output holds S_APPLY.
// Reset empties the table, zeroes the break and loads header 24, limit 1048576.
// Depends on bfca_pkg, bfca_cell and best_fit_coalescing_allocator_macros.svh.
`default_nettype none
`include "best_fit_coalescing_allocator_macros.svh"
module best_fit_coalescing_allocator
  import bfca_pkg::*;
#(
  parameter int FREE_SLOTS = 64,
  parameter int ADDR_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // request_size [31:0], block_addr [63:32], block_size [95:64]
  input  wire logic [95:0] s_tdata,
  // kind [0]
  input  wire logic        s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // status [1:0], result_addr [33:2], granted_size [65:34], zero [71:66]
  output logic [71:0]      m_tdata,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int CW = $clog2(FREE_SLOTS + 1);
  localparam int TW = $clog2(FREE_SLOTS);
  localparam int AW = ADDR_BITS;
  localparam int SW = ((AW > 32) ? AW : 32) + 2;
  localparam logic [SW-1:0] LMAX = SW'(64'hFFFF_FFFF);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_CALC1, S_CALC2, S_CALC3, S_APPLY} state_t;

  state_t state;
  logic [6:0] hdr;
  logic [31:0] limit;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] bp, bp_next;
  logic [TW-1:0] t;

  logic kind;
  logic [31:0] size, len_in;
  logic [AW-1:0] c;

  logic ex_f, bf, fi_f;
  logic [CW-1:0] ex_idx, b_idx, i_idx;
  logic [AW-1:0] ex_start, b_start, p_start, n_start;
  logic [31:0] b_len, p_len, n_len;

  logic [SW-1:0] tot, pend, bpt, a1, p1, lh, lph, p2;
  logic [AW-1:0] hs, bp_hs, piece, bpn, piece_addr;
  logic [31:0] nlen, lenp, merged;
  logic fit, over, with_next, with_prev;

  logic [AW-1:0] cs [FREE_SLOTS];
  logic [31:0] cl [FREE_SLOTS];

  cell_ctl_t ctl;
  logic [CW-1:0] sel_idx, wr_idx;
  logic [AW-1:0] wr_start;
  logic [31:0] wr_len;
  logic [1:0] res_status;
  logic [AW-1:0] res_addr;
  logic [31:0] res_grant;
  logic [SW-1:0] addr_ext;
  logic go, head_valid;

  assign s_tready = (state == S_IDLE);
  assign go = !m_tvalid || m_tready;
  assign head_valid = CW'(t) < count;
  assign addr_ext = SW'(res_addr);

  for (genvar k = 0; k < FREE_SLOTS; k++) begin : g_cell
    localparam int L = (k == 0) ? 0 : k - 1;
    localparam int R = (k == FREE_SLOTS - 1) ? 0 : k + 1;
    bfca_cell #(.INDEX(k), .CW(CW), .AW(AW)) u_cell (
      .clk(clk), .ctl(ctl), .sel_idx(sel_idx), .wr_idx(wr_idx),
      .wr_start(wr_start), .wr_len(wr_len),
      .left_start(cs[L]), .left_len(cl[L]),
      .right_start(cs[R]), .right_len(cl[R]),
      .start(cs[k]), .len(cl[k])
    );
  end

  always_comb begin
    ctl = '{op: OP_HOLD, wr_en: 1'b0};
    sel_idx = '0;
    wr_idx = '0;
    wr_start = c;
    wr_len = lenp;
    res_status = STATUS_OK;
    res_addr = '0;
    res_grant = '0;
    count_next = count;
    bp_next = bp;
    if (state == S_SCAN) begin
      ctl.op = OP_ROTATE;
    end else if (state == S_APPLY && go) begin
      if (kind == KIND_ALLOC) begin
        if (ex_f) begin
          ctl.op = OP_DROP;
          sel_idx = ex_idx;
          count_next = count - CW'(1);
          res_addr = hs;
          res_grant = size;
        end else if (bf && fit) begin
          ctl.wr_en = 1'b1;
          wr_idx = b_idx;
          wr_start = b_start;
          wr_len = nlen;
          res_addr = piece_addr;
          res_grant = size;
        end else if (bf) begin
          ctl.op = OP_DROP;
          sel_idx = b_idx;
          count_next = count - CW'(1);
          res_addr = hs;
          res_grant = b_len;
        end else if (over) begin
          res_status = STATUS_NO_SPACE;
        end else begin
          res_addr = bp_hs;
          res_grant = size;
          bp_next = bpn;
        end
      end else begin
        if (with_prev) begin
          ctl.wr_en = 1'b1;
          wr_idx = i_idx - CW'(1);
          wr_start = p_start;
          wr_len = merged;
          if (with_next) begin
            ctl.op = OP_DROP;
            sel_idx = i_idx;
            count_next = count - CW'(1);
          end
        end else if (with_next) begin
          ctl.wr_en = 1'b1;
          wr_idx = i_idx;
        end else if (count >= CW'(FREE_SLOTS)) begin
          res_status = STATUS_TABLE_FULL;
        end else begin
          ctl.op = OP_PUT;
          ctl.wr_en = 1'b1;
          sel_idx = i_idx;
          wr_idx = i_idx;
          count_next = count + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hdr <= 7'd24;
      limit <= 32'd1048576;
      count <= '0;
      bp <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HEADER_SIZE: hdr <= cfg_data[6:0];
          REG_HEAP_LIMIT: limit <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state == S_APPLY && go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            kind <= s_tuser;
            size <= s_tdata[31:0];
            len_in <= s_tdata[95:64];
            c <= AW'(s_tdata[63:32]) - AW'(hdr);
            t <= '0;
            ex_f <= 1'b0;
            bf <= 1'b0;
            fi_f <= 1'b0;
            i_idx <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (head_valid) begin
            if (kind == KIND_ALLOC) begin
              if (!ex_f) begin
                if (cl[0] > size && (!bf || cl[0] < b_len)) begin
                  bf <= 1'b1;
                  b_idx <= CW'(t);
                  b_start <= cs[0];
                  b_len <= cl[0];
                end else if (cl[0] == size) begin
                  ex_f <= 1'b1;
                  ex_idx <= CW'(t);
                  ex_start <= cs[0];
                end
              end
            end else if (!fi_f) begin
              if (c < cs[0]) begin
                fi_f <= 1'b1;
                n_start <= cs[0];
                n_len <= cl[0];
              end else begin
                p_start <= cs[0];
                p_len <= cl[0];
                i_idx <= CW'(t) + CW'(1);
              end
            end
          end
          t <= t + TW'(1);
          if (t == TW'(FREE_SLOTS - 1)) begin
            state <= S_CALC1;
          end
        end
        S_CALC1: begin
          tot <= SW'(size) + SW'(hdr);
          pend <= SW'(b_start) + SW'(b_len);
          hs <= (ex_f ? ex_start : b_start) + AW'(hdr);
          bp_hs <= bp + AW'(hdr);
          bpt <= SW'(bp) + SW'(size);
          a1 <= SW'(c) + SW'(hdr);
          p1 <= SW'(p_start) + SW'(hdr);
          lh <= SW'(len_in) + SW'(hdr);
          lph <= SW'(p_len) + SW'(hdr);
          state <= S_CALC2;
        end
        S_CALC2: begin
          piece <= AW'(pend - SW'(size));
          nlen <= 32'(SW'(b_len) - tot);
          fit <= SW'(b_len) > tot;
          over <= (bpt + SW'(hdr)) > SW'(limit);
          bpn <= AW'(bpt + SW'(hdr));
          if (i_idx < count && (a1 + SW'(len_in)) == SW'(n_start)
              && (lh + SW'(n_len)) <= LMAX) begin
            with_next <= 1'b1;
            lenp <= 32'(lh + SW'(n_len));
          end else begin
            with_next <= 1'b0;
            lenp <= len_in;
          end
          p2 <= p1 + SW'(p_len);
          state <= S_CALC3;
        end
        S_CALC3: begin
          piece_addr <= piece + AW'(hdr);
          with_prev <= i_idx != '0 && p2 == SW'(c) && (lph + SW'(lenp)) <= LMAX;
          merged <= 32'(lph + SW'(lenp));
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (go) begin
            m_tdata <= {6'd0, res_grant, addr_ext[31:0], res_status};
            count <= count_next;
            bp <= bp_next;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CW'(FREE_SLOTS))
  `ASSERT_NEXT(a_count_only_on_apply, clk, rst, state != S_APPLY, $stable(count))
  `ASSERT_NEXT(a_free_keeps_break, clk, rst, state == S_APPLY && kind == KIND_FREE, $stable(bp))
  `ASSERT_NEXT(a_apply_gives_result, clk, rst, state == S_APPLY && go, m_tvalid)
endmodule
`default_nettype wire
